// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high
`define SRLED_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define SRLED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/srled_pkg.sv
// ---------------------------------------------------------------------------
// srled_pkg
// Types and constants of the selective run-length decoder.
// ---------------------------------------------------------------------------
package srled_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 32;
  localparam int COUNT_W     = LEN_W + 1;
  localparam int MAP_DEPTH   = 1 << BYTE_W;
  localparam int LEN_SHIFT_W = 6;
  localparam int GROUP_W     = 7;

  // Length byte fields
  localparam logic [BYTE_W-1:0]      LEN_LOW_MASK  = 8'h7f;
  localparam logic [BYTE_W-1:0]      LEN_MORE_MASK = 8'h80;
  localparam logic [LEN_SHIFT_W-1:0] LEN_GROUP     = 6'd7;
  localparam logic [LEN_SHIFT_W-1:0] LEN_SHIFT_MAX = 6'd63;
  localparam logic [LEN_SHIFT_W-1:0] LEN_SHIFT_LIM = 6'd32;

  // Symbol map epochs; a tag of EPOCH_NONE means never marked
  localparam int                 EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_SYMS  = 2'd1,
    PH_DATA  = 2'd2,
    PH_LEN   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              start_of_block;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_symbol;
    logic [COUNT_W-1:0] repeat_count;
  } out_word_t;

  // Decoded result before the final +1 on the length
  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [LEN_W-1:0]  length;
  } q_entry_t;

  // Status of the queue as seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/selective_rle_decoder_core.sv
// ---------------------------------------------------------------------------
// selective_rle_decoder_core
// Selective run-length decoder with base-128 run lengths.
// ---------------------------------------------------------------------------
// Takes one byte of the encoded stream per cycle while enc_ready is high
// and gives each literal as (symbol, 1) and each run as (symbol, length+1)
// without expanding it. The front holds each accepted word in an input
// register while the symbol map is read, then decodes it with one tag
// compare and one shift-or; it takes a word every cycle as long as the
// two-entry queue has room. A word completed by a byte goes from the input
// register into the queue and then into the output register that adds the
// +1, where run_valid rises; the back drains one word per cycle while
// run_ready is high, so stalls on the output reach the input only once the
// queue is full. The 256-entry map keeps an 8-bit epoch tag per symbol; a
// count byte moves to the next epoch, which empties the map at once. After
// reset, and at the 255th count byte after each clear, a clear pass holds
// the input off (enc_ready low) while every tag is written back to zero.
module selective_rle_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enc_valid,
  output logic                 enc_ready,
  input  srled_pkg::in_word_t  enc_word,
  output logic                 run_valid,
  input  logic                 run_ready,
  output srled_pkg::out_word_t run_word
);

  srled_pkg::q_status_t q_status;
  srled_pkg::q_entry_t  push_entry;
  srled_pkg::q_entry_t  pop_entry;
  logic                 push_valid;
  logic                 pop;

  srled_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enc_valid  (enc_valid),
    .enc_ready  (enc_ready),
    .enc_word   (enc_word),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  srled_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_status   (q_status),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  srled_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_entry (pop_entry),
    .pop       (pop),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_word  (run_word)
  );

endmodule

// File: rtl/srled_front.sv
// ---------------------------------------------------------------------------
// srled_front
// Takes one stream byte per cycle, when enc_ready is high, into an input
// register while the symbol map is read, then tracks the block phase, marks
// run-coded symbols and gathers base-128 run lengths. Pushes decoded words.
// ---------------------------------------------------------------------------
module srled_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enc_valid,
  output logic                 enc_ready,
  input  srled_pkg::in_word_t  enc_word,
  input  srled_pkg::q_status_t q_status,
  output logic                 push_valid,
  output srled_pkg::q_entry_t  push_entry
);

  srled_pkg::phase_t                      phase;
  srled_pkg::phase_t                      phase_next;
  logic [srled_pkg::BYTE_W-1:0]           symbols_left;
  logic [srled_pkg::BYTE_W-1:0]           symbols_left_next;
  logic [srled_pkg::BYTE_W-1:0]           pending_symbol;
  logic [srled_pkg::BYTE_W-1:0]           pending_symbol_next;
  logic [srled_pkg::LEN_W-1:0]            length_acc;
  logic [srled_pkg::LEN_W-1:0]            length_acc_next;
  logic [srled_pkg::LEN_SHIFT_W-1:0]      length_shift;
  logic [srled_pkg::LEN_SHIFT_W-1:0]      length_shift_next;

  // Symbol map: one epoch tag per byte value, current epoch means marked
  logic [srled_pkg::EPOCH_W-1:0]          tag_mem [srled_pkg::MAP_DEPTH];
  logic [srled_pkg::EPOCH_W-1:0]          epoch;
  logic                                   clearing;
  logic [srled_pkg::BYTE_W-1:0]           clr_addr;

  // Input register and the tag read for it
  logic                                   held_valid;
  srled_pkg::in_word_t                    held_word;
  logic [srled_pkg::EPOCH_W-1:0]          held_tag;

  logic                                   accept;
  logic                                   step;
  logic                                   opening;
  logic                                   mark_wr;
  logic [srled_pkg::BYTE_W-1:0]           b;
  logic [srled_pkg::BYTE_W-1:0]           rd_addr;
  logic                                   marked;
  logic                                   more;
  logic [srled_pkg::LEN_W-1:0]            group_bits;
  logic [srled_pkg::LEN_W-1:0]            acc_merged;
  logic [srled_pkg::LEN_SHIFT_W:0]        shift_sum;
  logic [srled_pkg::LEN_SHIFT_W-1:0]      shift_sat;

  assign enc_ready = !clearing && (!held_valid || !q_status.full);
  assign accept    = enc_valid && enc_ready;
  assign step      = held_valid && !clearing && !q_status.full;
  assign rd_addr   = enc_word.in_byte;
  assign b         = held_word.in_byte;
  assign opening   = held_word.start_of_block || (phase == srled_pkg::PH_COUNT);
  assign mark_wr   = step && !opening && (phase == srled_pkg::PH_SYMS);
  assign marked    = (held_tag == epoch);
  assign more      = (b & srled_pkg::LEN_MORE_MASK) != '0;

  // Length group merge and shift step
  assign group_bits = {{(srled_pkg::LEN_W-srled_pkg::BYTE_W){1'b0}},
                       (b & srled_pkg::LEN_LOW_MASK)};
  assign acc_merged = (length_shift < srled_pkg::LEN_SHIFT_LIM)
                    ? (length_acc | (group_bits << length_shift[4:0]))
                    : length_acc;
  assign shift_sum  = {1'b0, length_shift} + {1'b0, srled_pkg::LEN_GROUP};
  assign shift_sat  = (shift_sum > {1'b0, srled_pkg::LEN_SHIFT_MAX})
                    ? srled_pkg::LEN_SHIFT_MAX
                    : shift_sum[srled_pkg::LEN_SHIFT_W-1:0];

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (opening) begin
        phase_next = (b != '0) ? srled_pkg::PH_SYMS : srled_pkg::PH_DATA;
      end else begin
        unique case (phase)
          srled_pkg::PH_SYMS: begin
            if (symbols_left == 8'd1) phase_next = srled_pkg::PH_DATA;
          end
          srled_pkg::PH_DATA: begin
            if (marked) phase_next = srled_pkg::PH_LEN;
          end
          srled_pkg::PH_LEN: begin
            if (!more) phase_next = srled_pkg::PH_DATA;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // Outputs and datapath next values
  always_comb begin
    push_valid          = 1'b0;
    push_entry.symbol   = b;
    push_entry.length   = '0;
    symbols_left_next   = symbols_left;
    pending_symbol_next = pending_symbol;
    length_acc_next     = length_acc;
    length_shift_next   = length_shift;
    if (step) begin
      if (opening) begin
        symbols_left_next   = b;
        pending_symbol_next = '0;
        length_acc_next     = '0;
        length_shift_next   = '0;
      end else begin
        unique case (phase)
          srled_pkg::PH_SYMS: begin
            symbols_left_next = symbols_left - 8'd1;
          end
          srled_pkg::PH_DATA: begin
            if (marked) begin
              pending_symbol_next = b;
              length_acc_next     = '0;
              length_shift_next   = '0;
            end else begin
              // literal: length 0 means count 1
              push_valid = 1'b1;
            end
          end
          srled_pkg::PH_LEN: begin
            if (more) begin
              length_acc_next   = acc_merged;
              length_shift_next = shift_sat;
            end else begin
              push_valid        = 1'b1;
              push_entry.symbol = pending_symbol;
              push_entry.length = acc_merged;
              length_acc_next   = '0;
              length_shift_next = '0;
            end
          end
          default: push_valid = 1'b0;
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= srled_pkg::PH_COUNT;
      symbols_left <= '0;
    end else begin
      phase        <= phase_next;
      symbols_left <= symbols_left_next;
    end
  end

  // Run length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_symbol <= '0;
      length_acc     <= '0;
      length_shift   <= '0;
    end else begin
      pending_symbol <= pending_symbol_next;
      length_acc     <= length_acc_next;
      length_shift   <= length_shift_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_word <= enc_word;
  end

  // Epoch: a count byte moves to a fresh epoch, which empties the map.
  // Once the epochs run out, a clear pass walks all entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      epoch    <= srled_pkg::EPOCH_FIRST;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end else if (step && opening) begin
      if (epoch == '1) begin
        clearing <= 1'b1;
        clr_addr <= '0;
        epoch    <= srled_pkg::EPOCH_FIRST;
      end else begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  // Map write: clear pass or marking a listed symbol
  always_ff @(posedge clk) begin
    if (clearing) begin
      tag_mem[clr_addr] <= srled_pkg::EPOCH_NONE;
    end else if (mark_wr) begin
      tag_mem[b] <= epoch;
    end
  end

  // Map read for the incoming byte, with the same-cycle mark forwarded
  always_ff @(posedge clk) begin
    if (clearing) begin
      held_tag <= srled_pkg::EPOCH_NONE;
    end else if (accept) begin
      held_tag <= (mark_wr && (b == rd_addr)) ? epoch : tag_mem[rd_addr];
    end
  end

endmodule

// File: rtl/srled_queue.sv
// ---------------------------------------------------------------------------
// srled_queue
// Short queue of decoded words between the front and the back.
// ---------------------------------------------------------------------------
module srled_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  srled_pkg::q_entry_t  push_entry,
  output srled_pkg::q_status_t q_status,
  input  logic                 pop,
  output srled_pkg::q_entry_t  pop_entry
);

  srled_pkg::q_entry_t              slots [srled_pkg::QUEUE_DEPTH];
  logic [srled_pkg::QPTR_W-1:0]     wr_ptr;
  logic [srled_pkg::QPTR_W-1:0]     rd_ptr;
  logic [srled_pkg::QCNT_W-1:0]     fill;
  logic                             do_push;
  logic                             do_pop;

  assign q_status.full  = (fill == srled_pkg::QCNT_W'(srled_pkg::QUEUE_DEPTH));
  assign q_status.empty = (fill == '0);
  assign do_push        = push_valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_entry      = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == srled_pkg::QPTR_W'(srled_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == srled_pkg::QPTR_W'(srled_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

// File: rtl/srled_back.sv
// ---------------------------------------------------------------------------
// srled_back
// Turns a queued length into the repeat count and holds the result word in
// the output register until it is taken.
// ---------------------------------------------------------------------------
module srled_back (
  input  logic                 clk,
  input  logic                 rst,
  input  srled_pkg::q_status_t q_status,
  input  srled_pkg::q_entry_t  pop_entry,
  output logic                 pop,
  output logic                 run_valid,
  input  logic                 run_ready,
  output srled_pkg::out_word_t run_word
);

  logic [srled_pkg::COUNT_W-1:0] count_next;

  assign pop        = !q_status.empty && (!run_valid || run_ready);
  assign count_next = {1'b0, pop_entry.length} + srled_pkg::COUNT_W'(1);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (pop) begin
      run_valid <= 1'b1;
    end else if (run_ready) begin
      run_valid <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (pop) begin
      run_word.out_symbol   <= pop_entry.symbol;
      run_word.repeat_count <= count_next;
    end
  end

endmodule

// File: rtl/srled_checker.sv
// ---------------------------------------------------------------------------
// srled_checker
// Port-level checks of the decoder core, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srled_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 enc_valid,
  input logic                 enc_ready,
  input srled_pkg::in_word_t  enc_word,
  input logic                 run_valid,
  input logic                 run_ready,
  input srled_pkg::out_word_t run_word
);

  // A stalled result word holds
  `SRLED_ASSERT(a_run_hold, clk, rst, run_valid && !run_ready |=> run_valid && $stable(run_word), "result word changed while stalled")

  // Count is never zero
  `SRLED_ASSERT(a_count_nonzero, clk, rst, run_valid |-> run_word.repeat_count != '0, "zero repeat count")

  // Count above 2^32 cannot occur
  `SRLED_ASSERT(a_count_range, clk, rst, run_valid && run_word.repeat_count[32] |-> run_word.repeat_count[31:0] == '0, "repeat count out of range")

  // Reset empties the output and holds the input off while the map clears
  `SRLED_ASSERT_ALWAYS(a_reset_out, clk, rst |=> !run_valid, "result word valid after reset")
  `SRLED_ASSERT_ALWAYS(a_reset_in, clk, rst |=> !enc_ready, "input ready during map clear")

endmodule

bind selective_rle_decoder_core srled_checker u_srled_checker (.*);

// File: sim/selective_rle_decoder_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_rle_decoder_core_tb
// Self-checking bench for the selective run-length decoder core.
// ---------------------------------------------------------------------------
// Drives encoded bytes through the valid/ready input and keeps its own model
// of the decoder: block headers, the marked-symbol map and base-128 run
// lengths. Each predicted (symbol, count) word is queued and compared with
// the words that leave the core, in order. A directed opening covers the
// corner cases, then random blocks run under three idle patterns, with one
// long output stall that backs the core up into its input.
// ---------------------------------------------------------------------------

class rle_scoreboard;
  int unsigned                             err_cnt;
  srled_pkg::out_word_t                    expected_runs[$];

  // Decoder model state
  srled_pkg::phase_t                       cur_phase;
  logic [srled_pkg::BYTE_W-1:0]            syms_left;
  logic [srled_pkg::MAP_DEPTH-1:0]         marked;
  logic [srled_pkg::BYTE_W-1:0]            run_sym;
  logic [srled_pkg::LEN_W-1:0]             run_len;
  logic [srled_pkg::LEN_SHIFT_W-1:0]       len_pos;

  function new();
    err_cnt   = 0;
    cur_phase = srled_pkg::PH_COUNT;
    syms_left = '0;
    marked    = '0;
    run_sym   = '0;
    run_len   = '0;
    len_pos   = '0;
  endfunction

  task report_mismatch(string what);
    if (err_cnt < 100) $display("tb: mismatch: %s", what);
    err_cnt++;
  endtask

  // Advance the model by one byte; returns 1 when a word comes out
  function bit decode_byte(srled_pkg::in_word_t w, output srled_pkg::out_word_t r);
    logic [srled_pkg::BYTE_W-1:0] b;
    logic [srled_pkg::LEN_W-1:0]  grp;
    b = w.in_byte;
    r = '0;
    // Count byte: open a new block, drop anything half read
    if (w.start_of_block || cur_phase == srled_pkg::PH_COUNT) begin
      marked    = '0;
      syms_left = b;
      run_sym   = '0;
      run_len   = '0;
      len_pos   = '0;
      cur_phase = (b != 0) ? srled_pkg::PH_SYMS : srled_pkg::PH_DATA;
      return 1'b0;
    end
    case (cur_phase)
      srled_pkg::PH_SYMS: begin
        marked[b] = 1'b1;
        syms_left = syms_left - 1'b1;
        if (syms_left == 0) cur_phase = srled_pkg::PH_DATA;
        return 1'b0;
      end
      srled_pkg::PH_DATA: begin
        if (marked[b]) begin
          run_sym   = b;
          run_len   = '0;
          len_pos   = '0;
          cur_phase = srled_pkg::PH_LEN;
          return 1'b0;
        end
        r.out_symbol   = b;
        r.repeat_count = srled_pkg::COUNT_W'(1);
        return 1'b1;
      end
      default: begin
        // Length byte: 7 bits per group, bits past 31 are lost
        grp = {{(srled_pkg::LEN_W-srled_pkg::BYTE_W){1'b0}}, b & srled_pkg::LEN_LOW_MASK};
        if (len_pos < srled_pkg::LEN_SHIFT_LIM) run_len = run_len | (grp << len_pos);
        len_pos = (int'(len_pos) + int'(srled_pkg::LEN_GROUP) >
                   int'(srled_pkg::LEN_SHIFT_MAX)) ?
                  srled_pkg::LEN_SHIFT_MAX : len_pos + srled_pkg::LEN_GROUP;
        if ((b & srled_pkg::LEN_MORE_MASK) != 0) return 1'b0;
        r.out_symbol   = run_sym;
        r.repeat_count = {1'b0, run_len} + srled_pkg::COUNT_W'(1);
        run_len   = '0;
        len_pos   = '0;
        cur_phase = srled_pkg::PH_DATA;
        return 1'b1;
      end
    endcase
  endfunction

  function void take_enc_word(srled_pkg::in_word_t w);
    srled_pkg::out_word_t r;
    if (decode_byte(w, r)) expected_runs.push_back(r);
  endfunction

  task check_run_word(srled_pkg::out_word_t got);
    srled_pkg::out_word_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected word sym=%02h cnt=%0d",
                                got.out_symbol, got.repeat_count));
      return;
    end
    want = expected_runs.pop_front();
    if (got.out_symbol !== want.out_symbol)
      report_mismatch($sformatf("out_symbol %02h, want %02h",
                                got.out_symbol, want.out_symbol));
    if (got.repeat_count !== want.repeat_count)
      report_mismatch($sformatf("repeat_count %0d, want %0d (sym %02h)",
                                got.repeat_count, want.repeat_count, want.out_symbol));
  endtask

  function int pending_count();
    return expected_runs.size();
  endfunction
endclass

module selective_rle_decoder_core_tb;

  localparam int RANDOM_BYTES = 750;
  localparam int STALL_CYCLES = 300;

  logic                 clk;
  logic                 rst;
  logic                 enc_valid;
  logic                 enc_ready;
  srled_pkg::in_word_t  enc_word;
  logic                 run_valid;
  logic                 run_ready;
  srled_pkg::out_word_t run_word;

  rle_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int sent_cnt;
  int stall_reqs;
  int stall_seen;
  int hold_left;

  selective_rle_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc_word  (enc_word),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_word  (run_word)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random back-pressure plus long holds on request
  initial begin
    run_ready  = 1'b0;
    stall_seen = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_seen != stall_reqs) begin
        stall_seen = stall_reqs;
        hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        run_ready = 1'b0;
        hold_left--;
      end else begin
        run_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && run_valid && run_ready) sb.check_run_word(run_word);
  end

  // Offer one word; called just after a falling edge, returns just after one
  task automatic push_byte(input logic [srled_pkg::BYTE_W-1:0] b, input logic s);
    srled_pkg::in_word_t w;
    // idle cycles before the word, one draw per cycle
    while ($urandom_range(0, 99) < send_idle_pct) begin
      enc_valid = 1'b0;
      @(negedge clk);
    end
    w.in_byte        = b;
    w.start_of_block = s;
    enc_word  = w;
    enc_valid = 1'b1;
    do @(posedge clk); while (!enc_ready);
    sb.take_enc_word(w);
    sent_cnt++;
    @(negedge clk);
  endtask

  // One block: header, symbol list, then literals and runs; may break off
  task automatic send_random_block(input int force_cnt);
    logic [srled_pkg::MAP_DEPTH-1:0] chosen;
    logic [srled_pkg::BYTE_W-1:0]    sym_list[$];
    logic [srled_pkg::BYTE_W-1:0]    b;
    int                              n_syms;
    int                              n_send;
    int                              n_data;
    int                              n_len;
    int                              r;
    int                              tries;
    chosen = '0;
    r = $urandom_range(0, 99);
    if (force_cnt >= 0) n_syms = force_cnt;
    else if (r < 12) n_syms = 0;
    else if (r < 15) n_syms = $urandom_range(9, 40);
    else n_syms = $urandom_range(1, 8);
    push_byte(srled_pkg::BYTE_W'(n_syms), 1'b1);

    // Symbol list, sometimes cut short by the next block
    n_send = n_syms;
    if (n_syms > 0 && $urandom_range(0, 99) < 5) n_send = $urandom_range(0, n_syms - 1);
    for (int i = 0; i < n_send; i++) begin
      if (sym_list.size() > 0 && $urandom_range(0, 99) < 30)
        b = sym_list[$urandom_range(0, sym_list.size() - 1)];
      else
        b = srled_pkg::BYTE_W'($urandom_range(0, 255));
      chosen[b] = 1'b1;
      sym_list.push_back(b);
    end
    for (int i = 0; i < n_send; i++) push_byte(sym_list[i], 1'b0);
    if (n_send < n_syms) return;

    n_data = $urandom_range(1, 24);
    for (int i = 0; i < n_data; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise, now and then a stray block start
        push_byte(srled_pkg::BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
      end else if (r < 55 && sym_list.size() > 0) begin
        // run: marked symbol and its length bytes
        push_byte(sym_list[$urandom_range(0, sym_list.size() - 1)], 1'b0);
        n_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        if ($urandom_range(0, 99) < 5) begin
          for (int j = 0; j < n_len - 1; j++)
            push_byte(srled_pkg::BYTE_W'($urandom_range(0, 127)) | srled_pkg::LEN_MORE_MASK,
                      1'b0);
          push_byte(srled_pkg::BYTE_W'($urandom_range(0, 255)) | srled_pkg::LEN_MORE_MASK,
                    1'b0);
          return;
        end
        for (int j = 0; j < n_len; j++) begin
          b = srled_pkg::BYTE_W'($urandom_range(0, 127));
          if (j < n_len - 1) b = b | srled_pkg::LEN_MORE_MASK;
          push_byte(b, 1'b0);
        end
      end else begin
        // literal: try for a symbol that is not marked
        tries = 0;
        do begin
          b = srled_pkg::BYTE_W'($urandom_range(0, 255));
          tries++;
        end while (chosen[b] && tries < 40);
        push_byte(b, 1'b0);
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    rst           = 1'b1;
    enc_valid     = 1'b0;
    enc_word      = '0;
    send_idle_pct = 19;
    recv_idle_pct = 60;
    sent_cnt      = 0;
    stall_reqs    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Count byte right after reset without the start mark, repeated symbol
    push_byte(8'h03, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    // Zero length gives a count of one; a literal, then a two-byte length
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    // Block start in the middle of a length, with a zero count
    push_byte(8'h00, 1'b0);
    push_byte(8'h85, 1'b0);
    push_byte(8'h83, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    // Block start in the middle of a symbol list
    push_byte(8'h02, 1'b1);
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h10, 1'b0);
    // Overlong all-ones length: shift saturates, count is 2^32
    push_byte(8'h01, 1'b1);
    push_byte(8'haa, 1'b0);
    push_byte(8'haa, 1'b0);
    for (int i = 0; i < 9; i++) push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);

    // Random: sender idles little, receiver often
    while (sent_cnt < RANDOM_BYTES / 3) send_random_block(-1);

    // Receiver idles little, sender often; one full 255-symbol list
    send_idle_pct = 60;
    recv_idle_pct = 19;
    send_random_block(255);
    while (sent_cnt < 2 * RANDOM_BYTES / 3) send_random_block(-1);

    // No idling; a long receiver hold while the input keeps coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_reqs++;
    while (sent_cnt < RANDOM_BYTES) send_random_block(-1);
    enc_valid = 1'b0;

    // Drain
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
